// ===== src/gsvp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsvp_pkg
// Shared types and codes of the gshare value predictor: transaction payloads,
// configuration registers, function and internal operation codes.
// ----------------------------------------------------------------------------
package gsvp_pkg;

  // request payload
  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] pc;
    logic [31:0] history_in;
    logic [63:0] train_value;
    logic        taken;
  } req_t;

  // response payload
  typedef struct packed {
    logic        confident_hit;
    logic [63:0] predicted_value;
    logic [31:0] current_history;
  } rsp_t;

  // configuration registers
  typedef struct packed {
    logic       enable;
    logic [3:0] index_bits;
    logic [4:0] tag_bits;
    logic [3:0] conf_max;
    logic [5:0] history_bits;
  } cfg_t;

  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAG_BITS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CONF_MAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_BITS = 3'd4;

  localparam cfg_t CFG_RESET = '{
    enable:       1'b1,
    index_bits:   4'd10,
    tag_bits:     5'd8,
    conf_max:     4'd3,
    history_bits: 6'd10
  };

  // request function codes
  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_TRAIN  = 2'd1;
  localparam logic [1:0] FUNC_HIST   = 2'd2;

  // classified operations passed from front to back
  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_TRAIN  = 2'd2;
  localparam logic [1:0] OP_HIST   = 2'd3;

endpackage
`default_nettype wire

// ===== src/gshare_value_predictor_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gshare_value_predictor_top
// Last-value predictor with a gshare-indexed, tag-checked table.
// ----------------------------------------------------------------------------
// path: queue slot, then response register for history and no-op requests;
//   lookup/train add a single-port table read register, then evaluate/write
// throughput: a lookup or train holds the back end through the table's
//   read-modify-write; other requests one per cycle unless rsp_stall holds them
// reset: synchronous; then a pass clears all 2**MAX_INDEX_BITS table entries
//   (1024 by default) with req_stall high; config writes are taken throughout
module gshare_value_predictor_top #(
  parameter int MAX_INDEX_BITS   = 10,
  parameter int MAX_TAG_BITS     = 16,
  parameter int MAX_HISTORY_BITS = 32,
  parameter int CONF_WIDTH       = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  gsvp_pkg::req_t                     req,
  input  logic                               req_valid,
  output logic                               req_stall,
  output gsvp_pkg::rsp_t                     rsp,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  input  logic                               cfg_wen,
  input  logic [gsvp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gsvp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import gsvp_pkg::*;

  localparam int QW = MAX_INDEX_BITS + MAX_TAG_BITS + 67;

  cfg_t          cfg;
  logic          busy;
  logic          q_push;
  logic [QW-1:0] q_push_data;
  logic          q_full;
  logic          q_pop;
  logic          q_not_empty;
  logic [QW-1:0] q_pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_ENABLE:       cfg.enable       <= cfg_wdata[0];
        CFG_INDEX_BITS:   cfg.index_bits   <= cfg_wdata[3:0];
        CFG_TAG_BITS:     cfg.tag_bits     <= cfg_wdata[4:0];
        CFG_CONF_MAX:     cfg.conf_max     <= cfg_wdata[3:0];
        CFG_HISTORY_BITS: cfg.history_bits <= cfg_wdata[5:0];
        default: begin
        end
      endcase
    end
  end

  gsvp_front #(
    .IW (MAX_INDEX_BITS),
    .TW (MAX_TAG_BITS),
    .HW (MAX_HISTORY_BITS)
  ) u_front (
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cfg       (cfg),
    .busy      (busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_push_data)
  );

  gsvp_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_pop_data)
  );

  gsvp_back #(
    .IW (MAX_INDEX_BITS),
    .TW (MAX_TAG_BITS),
    .HW (MAX_HISTORY_BITS),
    .CW (CONF_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_not_empty),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .busy      (busy),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

endmodule
`default_nettype wire

// ===== src/gsvp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsvp_queue
// Two-entry queue between the classifying front and the table back end.
// ----------------------------------------------------------------------------
module gsvp_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] slot [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue pushed while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue popped while empty");
`endif

endmodule
`default_nettype wire

// ===== src/gsvp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsvp_front
// Accepts requests, computes the gshare index and tag hash and classifies
// each request into an operation for the back end.
// ----------------------------------------------------------------------------
module gsvp_front #(
  parameter int IW = 10,
  parameter int TW = 16,
  parameter int HW = 32
) (
  input  gsvp_pkg::req_t      req,
  input  logic                req_valid,
  output logic                req_stall,
  input  gsvp_pkg::cfg_t      cfg,
  input  logic                busy,
  input  logic                q_full,
  output logic                q_push,
  output logic [IW+TW+66:0]   q_data
);
  import gsvp_pkg::*;

  localparam int IBW = $clog2(IW + 1);

  logic [61:0]    pc_w;
  logic [31:0]    hmask;
  logic [31:0]    hist;
  logic [IW-1:0]  imask;
  logic [IW-1:0]  idx;
  logic [IBW-1:0] eff_ib;
  logic [61:0]    tag_src;
  logic [TW-1:0]  tmask;
  logic [TW-1:0]  tag;
  logic [1:0]     op;

  assign pc_w = req.pc[63:2];

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      hmask[i] = (i < int'(cfg.history_bits)) && (i < HW);
    end
    for (int i = 0; i < IW; i++) begin
      imask[i] = (i < int'(cfg.index_bits));
    end
    for (int i = 0; i < TW; i++) begin
      tmask[i] = (i < int'(cfg.tag_bits));
    end
  end

  assign hist    = req.history_in & hmask;
  assign idx     = (pc_w[IW-1:0] ^ hist[IW-1:0]) & imask;
  assign eff_ib  = (int'(cfg.index_bits) > IW) ? IBW'(IW) : IBW'(cfg.index_bits);
  assign tag_src = pc_w >> eff_ib;
  assign tag     = (tag_src[TW-1:0] ^ hist[TW-1:0]) & tmask;

  always_comb begin
    unique case (req.func)
      FUNC_LOOKUP: op = cfg.enable ? OP_LOOKUP : OP_NONE;
      FUNC_TRAIN:  op = cfg.enable ? OP_TRAIN : OP_NONE;
      FUNC_HIST:   op = OP_HIST;
      default:     op = OP_NONE;
    endcase
  end

  assign req_stall = q_full || busy;
  assign q_push    = req_valid && !req_stall;
  assign q_data    = {op, idx, tag, req.train_value, req.taken};

endmodule
`default_nettype wire

// ===== src/gsvp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsvp_back
// Owns the predictor table and the global history. Clears the table after
// reset, then runs lookups and read-modify-write training one at a time.
// ----------------------------------------------------------------------------
module gsvp_back #(
  parameter int IW = 10,
  parameter int TW = 16,
  parameter int HW = 32,
  parameter int CW = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  gsvp_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  logic [IW+TW+66:0]   q_data,
  output logic                q_pop,
  output logic                busy,
  output gsvp_pkg::rsp_t      rsp,
  output logic                rsp_valid,
  input  logic                rsp_stall
);
  import gsvp_pkg::*;

  localparam int DEPTH = 1 << IW;
  localparam int EW    = 1 + TW + 64 + CW;
  localparam int CONF_TOP = (1 << CW) - 1;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [IW-1:0] clr_cnt;

  // queue entry fields
  logic [1:0]    q_op;
  logic [IW-1:0] q_idx;
  logic [TW-1:0] q_tag;
  logic [63:0]   q_value;
  logic          q_taken;

  // operation held while the table read is in flight
  logic [1:0]    cur_op;
  logic [IW-1:0] cur_idx;
  logic [TW-1:0] cur_tag;
  logic [63:0]   cur_value;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_data;
  logic          rd_en;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic          e_valid;
  logic [TW-1:0] e_tag;
  logic [63:0]   e_value;
  logic [CW-1:0] e_conf;

  logic          n_valid;
  logic [TW-1:0] n_tag;
  logic [63:0]   n_value;
  logic [CW-1:0] n_conf;

  logic [CW-1:0] ecm;
  logic          match;
  logic          out_free;
  logic          load_rsp;
  logic          rsp_hit;
  logic [63:0]   rsp_pred;
  rsp_t          rsp_d;

  logic [HW-1:0] gh;
  logic [HW-1:0] gh_next;
  logic [HW-1:0] ghmask;
  logic [63:0]   gh_ext;

  assign {q_op, q_idx, q_tag, q_value, q_taken} = q_data;
  assign {e_valid, e_tag, e_value, e_conf} = rd_data;

  assign busy     = (state == ST_CLEAR);
  assign out_free = !rsp_valid || !rsp_stall;
  assign ecm      = (int'(cfg.conf_max) > CONF_TOP) ? CW'(CONF_TOP) : CW'(cfg.conf_max);
  assign match    = e_valid && ((cfg.tag_bits == 5'd0) || (e_tag == cur_tag));

  always_comb begin
    for (int i = 0; i < HW; i++) begin
      ghmask[i] = (i < int'(cfg.history_bits));
    end
  end

  // training update of the entry just read
  always_comb begin
    n_valid = e_valid;
    n_tag   = e_tag;
    n_value = e_value;
    n_conf  = e_conf;
    if (match) begin
      if (e_value == cur_value) begin
        if (e_conf < ecm) begin
          n_conf = e_conf + CW'(1);
        end
      end else if (e_conf != '0) begin
        n_conf = e_conf - CW'(1);
      end else begin
        n_value = cur_value;
      end
    end else begin
      n_valid = 1'b1;
      n_tag   = cur_tag;
      n_value = cur_value;
      n_conf  = '0;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = cur_idx;
    wr_data    = {n_valid, n_tag, n_value, n_conf};
    load_rsp   = 1'b0;
    gh_next    = gh;
    rsp_hit    = 1'b0;
    rsp_pred   = '0;
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = '0;
        if (&clr_cnt) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          if ((q_op == OP_LOOKUP) || (q_op == OP_TRAIN)) begin
            q_pop      = 1'b1;
            rd_en      = 1'b1;
            state_next = ST_EVAL;
          end else if (out_free) begin
            q_pop    = 1'b1;
            load_rsp = 1'b1;
            if (q_op == OP_HIST) begin
              gh_next = ((gh << 1) | HW'(q_taken)) & ghmask;
            end
          end
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          load_rsp   = 1'b1;
          state_next = ST_IDLE;
          if (cur_op == OP_LOOKUP) begin
            rsp_hit  = match && (e_conf == ecm);
            rsp_pred = e_value;
          end else begin
            wr_en = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign gh_ext = 64'(gh_next);
  assign rsp_d  = {rsp_hit, rsp_pred, gh_ext[31:0]};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[q_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_op    <= q_op;
      cur_idx   <= q_idx;
      cur_tag   <= q_tag;
      cur_value <= q_value;
    end
    if (load_rsp) begin
      rsp <= rsp_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      gh        <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      gh    <= gh_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + IW'(1);
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_quiet_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !rsp_valid)
    else $error("response during table clear");
  a_eval_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL && !out_free) |=> state == ST_EVAL)
    else $error("table operation dropped while output blocked");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == ST_IDLE)
    else $error("queue popped outside idle");
`endif

endmodule
`default_nettype wire
